// ===== hw/rtl/disk_seek_scheduler_top_assert.svh =====
// assertion macros for the disk seek scheduler checker
`ifndef DISK_SEEK_SCHEDULER_TOP_ASSERT_SVH
`define DISK_SEEK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define DSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("disk seek scheduler check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define DSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("disk seek scheduler check failed");

`endif

// ===== hw/rtl/dss_pkg.sv =====
// shared constants and types of the disk seek scheduler
package dss_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TRK_W = 16;
    localparam int SUM_W = 22;
    localparam int POS_W = 6;

    localparam logic [1:0] MODE_FCFS  = 2'd0;
    localparam logic [1:0] MODE_SSTF  = 2'd1;
    localparam logic [1:0] MODE_SCAN  = 2'd2;
    localparam logic [1:0] MODE_CSCAN = 2'd3;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;
    localparam logic [1:0] CFG_MAX   = 2'd2;
    localparam logic [1:0] CFG_DIR   = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic             dir;
        logic [TRK_W-1:0] head;
        logic [IDX_W-1:0] pos;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [TRK_W-1:0] wr_track;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
        logic             clr_all;
    } t_bcast;

    typedef struct packed {
        logic             found;
        logic [TRK_W-1:0] gap;
        logic [IDX_W-1:0] idx;
        logic [TRK_W-1:0] track;
        logic [TRK_W-1:0] top;
    } t_token;

endpackage

// ===== hw/rtl/dss_cell.sv =====
// one queue cell: holds a pending request and refines the passing search token
module dss_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [dss_pkg::IDX_W-1:0]   i_idx,
    input  dss_pkg::t_bcast             i_bc,
    input  dss_pkg::t_token             i_tok,
    output dss_pkg::t_token             o_tok
);
    import dss_pkg::*;

    logic             r_valid;
    logic [TRK_W-1:0] r_track;
    t_token           r_tok;
    t_token           n_tok;
    logic             w_hi;
    logic             w_ahead;
    logic             w_elig;
    logic             w_take;
    logic [TRK_W-1:0] w_dist;

    always_comb begin
        w_hi    = (r_track >= i_bc.head);
        w_dist  = w_hi ? (r_track - i_bc.head) : (i_bc.head - r_track);
        w_ahead = i_bc.dir ? w_hi : (r_track <= i_bc.head);
        unique case (i_bc.mode) inside
            MODE_FCFS: begin
                w_elig = r_valid && (i_idx == i_bc.pos);
            end
            MODE_SSTF: begin
                w_elig = r_valid;
            end
            MODE_SCAN, MODE_CSCAN: begin
                w_elig = r_valid && w_ahead;
            end
            default: begin
                w_elig = 1'b0;
            end
        endcase
        // strict compare keeps the earliest entry on a tie
        w_take = w_elig && (!i_tok.found || (w_dist < i_tok.gap));
        n_tok  = i_tok;
        if (w_take) begin
            n_tok.found = 1'b1;
            n_tok.gap   = w_dist;
            n_tok.idx   = i_idx;
            n_tok.track = r_track;
        end
        if (r_valid && (r_track > i_tok.top)) begin
            n_tok.top = r_track;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_bc.wr_en && (i_bc.wr_idx == i_idx)) begin
            r_track <= i_bc.wr_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_bc.clr_all) begin
            r_valid <= 1'b0;
        end else if (i_bc.wr_en && (i_bc.wr_idx == i_idx)) begin
            r_valid <= 1'b1;
        end else if (i_bc.clr_en && (i_bc.clr_idx == i_idx)) begin
            r_valid <= 1'b0;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/disk_seek_scheduler_top.sv =====
// disk seek scheduler top level: request queue chain, pick sequencer and registers
//
//  channel   direction  handshake                  payload
//  request   in         start & !busy              i_track, i_last_request
//  result    out        o_valid, one-cycle strobe  o_served_track .. o_last_result
//  config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// a request without the last mark is stored while the queue has room and busy stays low
// for each pick the search token walks the registered cell chain
// a scan reversal or circular scan jump costs one more walk of the chain
// busy is high from the last request until the final result leaves
// synchronous active-low reset clears the queue and loads the register defaults
module disk_seek_scheduler_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dss_pkg::TRK_W-1:0]   i_track,
    input  logic                        i_last_request,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [dss_pkg::TRK_W-1:0]   i_cfg_data,
    output logic                        o_valid,
    output logic [dss_pkg::TRK_W-1:0]   o_served_track,
    output logic [dss_pkg::TRK_W-1:0]   o_seek_distance,
    output logic [dss_pkg::SUM_W-1:0]   o_total_distance,
    output logic [dss_pkg::POS_W-1:0]   o_order_position,
    output logic                        o_last_result
);
    import dss_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic [1:0]       r_mode;
    logic [TRK_W-1:0] r_start_trk;
    logic [TRK_W-1:0] r_max_trk;
    logic             r_first_dir;

    logic             r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_cnt;
    logic [TRK_W-1:0] r_head;
    logic             r_dir;
    logic [SUM_W-1:0] r_sum;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_last_pos;

    logic             r_strobe;
    logic [TRK_W-1:0] r_served;
    logic [TRK_W-1:0] r_seek;
    logic [SUM_W-1:0] r_total;
    logic [POS_W-1:0] r_order;
    logic             r_last;

    logic             w_accept;
    logic             w_room;
    logic             w_done;
    logic             w_is_last;
    logic [SUM_W-1:0] n_sum;
    t_bcast           w_bc;
    t_token           w_tok [0:QUEUE_DEPTH];
    t_token           w_res;

    assign w_accept  = start && !busy;
    assign w_room    = (r_count < CNT_W'(QUEUE_DEPTH));
    assign w_res     = w_tok[QUEUE_DEPTH];
    assign w_done    = (r_state == S_SEARCH) && (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign w_is_last = (r_pos == r_last_pos);
    assign n_sum     = r_sum + SUM_W'(w_res.gap);

    always_comb begin
        w_bc.mode     = r_mode;
        w_bc.dir      = r_dir;
        w_bc.head     = r_head;
        w_bc.pos      = r_pos;
        w_bc.wr_en    = w_accept && w_room;
        w_bc.wr_idx   = r_count[IDX_W-1:0];
        w_bc.wr_track = i_track;
        w_bc.clr_en   = w_done && w_res.found;
        w_bc.clr_idx  = w_res.idx;
        w_bc.clr_all  = w_done && w_res.found && w_is_last;
    end

    assign w_tok[0] = '{found: 1'b0, gap: '0, idx: '0, track: '0, top: r_max_trk};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_bc    (w_bc),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_FCFS;
            r_start_trk <= TRK_W'(100);
            r_max_trk   <= TRK_W'(199);
            r_first_dir <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode      <= i_cfg_data[1:0];
                CFG_START: r_start_trk <= i_cfg_data;
                CFG_MAX:   r_max_trk   <= i_cfg_data;
                CFG_DIR:   r_first_dir <= i_cfg_data[0];
                default:   r_mode      <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_cnt      <= '0;
            r_head     <= TRK_W'(100);
            r_dir      <= 1'b0;
            r_sum      <= '0;
            r_pos      <= '0;
            r_last_pos <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_last_request) begin
                            r_state    <= S_SEARCH;
                            r_cnt      <= '0;
                            r_head     <= r_start_trk;
                            r_dir      <= r_first_dir;
                            r_sum      <= '0;
                            r_pos      <= '0;
                            r_last_pos <= w_room ? r_count[IDX_W-1:0]
                                                 : IDX_W'(QUEUE_DEPTH - 1);
                        end
                    end
                end
                S_SEARCH: begin
                    if (!w_done) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_cnt <= '0;
                        if (w_res.found) begin
                            r_strobe <= 1'b1;
                            r_head   <= w_res.track;
                            r_sum    <= n_sum;
                            r_pos    <= r_pos + IDX_W'(1);
                            if (w_is_last) begin
                                r_state <= S_IDLE;
                                r_count <= '0;
                            end
                        end else if (r_mode == MODE_SCAN) begin
                            r_dir <= ~r_dir;
                        end else if (!r_dir) begin
                            // jump to the high end, past max_track if a request lies there
                            r_head <= w_res.top;
                        end else begin
                            r_head <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_res.found) begin
            r_served <= w_res.track;
            r_seek   <= w_res.gap;
            r_total  <= n_sum;
            r_order  <= POS_W'(r_pos);
            r_last   <= w_is_last;
        end
    end

    assign busy             = (r_state == S_SEARCH);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_strobe;
    assign o_served_track   = r_served;
    assign o_seek_distance  = r_seek;
    assign o_total_distance = r_total;
    assign o_order_position = r_order;
    assign o_last_result    = r_last;

endmodule

// ===== hw/rtl/dss_checker.sv =====
// port-level checker for the disk seek scheduler, bound to the top level
`include "disk_seek_scheduler_top_assert.svh"

module dss_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_request,
    input logic o_valid,
    input logic o_last_result
);
    `DSS_ASSERT_IMP(a_result_from_batch, o_valid, $past(busy))
    `DSS_ASSERT_IMP(a_last_frees, o_valid && o_last_result, !busy)
    `DSS_ASSERT_IMP(a_busy_from_last, $rose(busy), $past(start && i_last_request))
    `DSS_ASSERT_NXT(a_no_back_to_back, o_valid, !o_valid)

endmodule

bind disk_seek_scheduler_top dss_checker u_dss_checker (.*);

// ===== sim/disk_seek_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the disk seek scheduler with a schedule predictor
module disk_seek_scheduler_top_tb;
    import dss_pkg::*;

    localparam int N_RANDOM    = 360;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 2 * (QUEUE_DEPTH + 1) + 8;

    typedef struct packed {
        logic [TRK_W-1:0] trk;
        logic [TRK_W-1:0] seek;
        logic [SUM_W-1:0] sum;
        logic [POS_W-1:0] pos;
        logic             fin;
    } t_svc;

    typedef struct packed {
        logic             cfg_en;
        logic [1:0]       mode;
        logic [TRK_W-1:0] start_trk;
        logic [TRK_W-1:0] max_trk;
        logic             dir_up;
        logic [TRK_W-1:0] trk;
        logic             fin;
        logic             typed;
        logic [TRK_W-1:0] seek;
        logic [SUM_W-1:0] sum;
    } t_plan_row;

    t_plan_row plan [22] = '{
        '{1'b0, MODE_FCFS,  16'd0,     16'd0,     1'b0, 16'd100,   1'b1, 1'b1, 16'd0,     22'd0},
        '{1'b0, MODE_FCFS,  16'd0,     16'd0,     1'b0, 16'd0,     1'b1, 1'b1, 16'd100,   22'd100},
        '{1'b0, MODE_FCFS,  16'd0,     16'd0,     1'b0, 16'd65535, 1'b1, 1'b1, 16'd65435, 22'd65435},
        '{1'b1, MODE_FCFS,  16'd0,     16'd199,   1'b0, 16'd65535, 1'b1, 1'b1, 16'd65535, 22'd65535},
        '{1'b1, MODE_SSTF,  16'd100,   16'd199,   1'b0, 16'd110,   1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SSTF,  16'd0,     16'd0,     1'b0, 16'd90,    1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SSTF,  16'd0,     16'd0,     1'b0, 16'd110,   1'b1, 1'b0, 16'd0,     22'd0},
        '{1'b1, MODE_SCAN,  16'd100,   16'd199,   1'b0, 16'd120,   1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SCAN,  16'd0,     16'd0,     1'b0, 16'd100,   1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SCAN,  16'd0,     16'd0,     1'b0, 16'd80,    1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SCAN,  16'd0,     16'd0,     1'b0, 16'd80,    1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SCAN,  16'd0,     16'd0,     1'b0, 16'd50,    1'b1, 1'b0, 16'd0,     22'd0},
        '{1'b1, MODE_CSCAN, 16'd100,   16'd199,   1'b0, 16'd150,   1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_CSCAN, 16'd0,     16'd0,     1'b0, 16'd60,    1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_CSCAN, 16'd0,     16'd0,     1'b0, 16'd250,   1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_CSCAN, 16'd0,     16'd0,     1'b0, 16'd120,   1'b1, 1'b0, 16'd0,     22'd0},
        '{1'b1, MODE_CSCAN, 16'd100,   16'd199,   1'b1, 16'd50,    1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_CSCAN, 16'd0,     16'd0,     1'b0, 16'd150,   1'b1, 1'b0, 16'd0,     22'd0},
        '{1'b1, MODE_CSCAN, 16'd65535, 16'd0,     1'b1, 16'd0,     1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_CSCAN, 16'd0,     16'd0,     1'b0, 16'd65535, 1'b1, 1'b0, 16'd0,     22'd0},
        '{1'b1, MODE_SCAN,  16'd0,     16'd65535, 1'b0, 16'd40,    1'b0, 1'b0, 16'd0,     22'd0},
        '{1'b0, MODE_SCAN,  16'd0,     16'd0,     1'b0, 16'd10,    1'b1, 1'b0, 16'd0,     22'd0}
    };

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic [TRK_W-1:0] i_track        = '0;
    logic             i_last_request = 1'b0;
    logic             i_cfg_valid    = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index    = CFG_MODE;
    logic [TRK_W-1:0] i_cfg_data     = '0;
    logic             o_valid;
    logic [TRK_W-1:0] o_served_track;
    logic [TRK_W-1:0] o_seek_distance;
    logic [SUM_W-1:0] o_total_distance;
    logic [POS_W-1:0] o_order_position;
    logic             o_last_result;

    // predictor state
    logic [1:0]       cfg_mode   = MODE_FCFS;
    logic [TRK_W-1:0] cfg_start  = 16'd100;
    logic [TRK_W-1:0] cfg_max    = 16'd199;
    logic             cfg_dir_up = 1'b0;
    logic [TRK_W-1:0] pend_trk  [QUEUE_DEPTH];
    logic             pend_live [QUEUE_DEPTH] = '{default: 1'b0};
    int               pend_cnt = 0;
    logic [TRK_W-1:0] head_trk = 16'd100;
    logic             sweep_up = 1'b0;

    t_svc svc_expect [$];
    int   err_cnt = 0;
    int   cyc_cnt = 0;
    int   sent    = 0;

    disk_seek_scheduler_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_track          (i_track),
        .i_last_request   (i_last_request),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_served_track   (o_served_track),
        .o_seek_distance  (o_seek_distance),
        .o_total_distance (o_total_distance),
        .o_order_position (o_order_position),
        .o_last_result    (o_last_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [TRK_W-1:0] trk_gap(input logic [TRK_W-1:0] a,
                                                 input logic [TRK_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // nearest live request, optionally only those at or ahead of the head
    function automatic int nearest_pick(input logic only_ahead);
        int               best;
        logic [TRK_W-1:0] best_gap;
        logic [TRK_W-1:0] g;
        best     = -1;
        best_gap = '0;
        for (int i = 0; i < pend_cnt; i++) begin
            if (!pend_live[i]) continue;
            if (only_ahead && (sweep_up ? (pend_trk[i] < head_trk) : (pend_trk[i] > head_trk)))
                continue;
            g = trk_gap(pend_trk[i], head_trk);
            if (best < 0 || g < best_gap) begin
                best     = i;
                best_gap = g;
            end
        end
        return best;
    endfunction

    function automatic void schedule_batch();
        int               idx;
        int               n;
        logic [TRK_W-1:0] hi;
        logic [TRK_W-1:0] g;
        logic [SUM_W-1:0] sum;
        t_svc             s;
        head_trk = cfg_start;
        sweep_up = cfg_dir_up;
        sum      = '0;
        n        = pend_cnt;
        for (int k = 0; k < n; k++) begin
            case (cfg_mode)
                MODE_FCFS: idx = k;
                MODE_SSTF: idx = nearest_pick(1'b0);
                MODE_SCAN: begin
                    idx = nearest_pick(1'b1);
                    if (idx < 0) begin
                        sweep_up = !sweep_up;
                        idx      = nearest_pick(1'b1);
                    end
                end
                default: begin
                    idx = nearest_pick(1'b1);
                    if (idx < 0) begin
                        if (!sweep_up) begin
                            hi = cfg_max;
                            for (int i = 0; i < pend_cnt; i++)
                                if (pend_live[i] && pend_trk[i] > hi) hi = pend_trk[i];
                            head_trk = hi;
                        end else begin
                            head_trk = '0;
                        end
                        idx = nearest_pick(1'b1);
                    end
                end
            endcase
            g              = trk_gap(pend_trk[idx], head_trk);
            pend_live[idx] = 1'b0;
            head_trk       = pend_trk[idx];
            sum            = sum + SUM_W'(g);
            s.trk          = pend_trk[idx];
            s.seek         = g;
            s.sum          = sum;
            s.pos          = k[POS_W-1:0];
            s.fin          = (k == n - 1);
            svc_expect.push_back(s);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) pend_live[i] = 1'b0;
        pend_cnt = 0;
    endfunction

    function automatic void take_request(input logic [TRK_W-1:0] trk, input logic fin);
        if (pend_cnt < QUEUE_DEPTH) begin
            pend_trk[pend_cnt]  = trk;
            pend_live[pend_cnt] = 1'b1;
            pend_cnt++;
        end
        if (fin) schedule_batch();
    endfunction

    task automatic send_request(input logic [TRK_W-1:0] trk, input logic fin);
        start          <= 1'b1;
        i_track        <= trk;
        i_last_request <= fin;
        do @(posedge i_clk); while (busy);
        take_request(trk, fin);
        sent++;
    endtask

    task automatic idle_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (svc_expect.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [TRK_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:  cfg_mode   = val[1:0];
            CFG_START: cfg_start  = val;
            CFG_MAX:   cfg_max    = val;
            default:   cfg_dir_up = val[0];
        endcase
    endtask

    task automatic program_regs(input logic [1:0] m, input logic [TRK_W-1:0] s,
                                input logic [TRK_W-1:0] mx, input logic d,
                                input bit all_regs, input bit quiet);
        logic [1:0]       regs [4];
        logic [TRK_W-1:0] val;
        regs = '{CFG_MODE, CFG_START, CFG_MAX, CFG_DIR};
        for (int r = 0; r < 4; r++) begin
            if (!all_regs && $urandom_range(0, 3) == 0) continue;
            case (regs[r])
                CFG_MODE:  val = {14'd0, m};
                CFG_START: val = s;
                CFG_MAX:   val = mx;
                default:   val = {15'd0, d};
            endcase
            cfg_write(regs[r], val);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_cfg_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_svc got;
        t_svc want;
        if (i_rst_n && o_valid) begin
            got = '{o_served_track, o_seek_distance, o_total_distance, o_order_position,
                    o_last_result};
            if (svc_expect.size() == 0) begin
                $display("%0t: unexpected result: track %0d seek %0d total %0d pos %0d last %0d",
                         $time, got.trk, got.seek, got.sum, got.pos, got.fin);
                err_cnt++;
            end else begin
                want = svc_expect.pop_front();
                if (got.trk !== want.trk || got.seek !== want.seek || got.sum !== want.sum ||
                    got.pos !== want.pos || got.fin !== want.fin) begin
                    $display("%0t: mismatch expected track %0d seek %0d total %0d pos %0d last %0d",
                             $time, want.trk, want.seek, want.sum, want.pos, want.fin);
                    $display("%0t:          actual   track %0d seek %0d total %0d pos %0d last %0d",
                             $time, got.trk, got.seek, got.sum, got.pos, got.fin);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_plan_row        row;
        t_svc             typed;
        int               n_batch;
        int               v;
        logic [1:0]       m;
        logic [TRK_W-1:0] s;
        logic [TRK_W-1:0] mx;
        logic [TRK_W-1:0] trk;
        logic             d;
        bit               quiet;
        bit               narrow;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.cfg_en) begin
                wait_idle();
                program_regs(row.mode, row.start_trk, row.max_trk, row.dir_up, 1'b1, 1'b0);
            end
            send_request(row.trk, row.fin);
            if (row.typed) begin
                void'(svc_expect.pop_back());
                typed = '{row.trk, row.seek, row.sum, '0, 1'b1};
                svc_expect.push_back(typed);
            end
            if ($urandom_range(0, 3) == 0) idle_gap();
        end

        while (sent < $size(plan) + N_RANDOM) begin
            quiet = (sent >= $size(plan) + N_RANDOM - 60);
            wait_idle();
            m = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       s = '0;
                1:       s = '1;
                2:       s = TRK_W'($urandom_range(0, 255));
                default: s = TRK_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       mx = '0;
                1:       mx = '1;
                2:       mx = 16'd199;
                default: mx = TRK_W'($urandom);
            endcase
            d = 1'($urandom_range(0, 1));
            program_regs(m, s, mx, d, $urandom_range(0, 3) == 0, quiet);

            // a few batches overfill the queue
            n_batch = ($urandom_range(0, 7) == 0) ? $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4)
                                                  : $urandom_range(1, QUEUE_DEPTH);
            narrow  = $urandom_range(0, 1);
            for (int k = 0; k < n_batch; k++) begin
                v = int'(cfg_start);
                v = v + int'($urandom_range(0, 40)) - 20;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                case ($urandom_range(0, 7))
                    0:             trk = $urandom_range(0, 1) ? '1 : '0;
                    1, 2, 3:       trk = narrow ? v[TRK_W-1:0] : TRK_W'($urandom);
                    default:       trk = narrow ? v[TRK_W-1:0] ^ {12'd0, 4'($urandom)}
                                                : TRK_W'($urandom);
                endcase
                send_request(trk, k == n_batch - 1);
                if (!quiet && $urandom_range(0, 3) == 0) idle_gap();
            end
        end

        start <= 1'b0;
        while (svc_expect.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_cnt == 0 && svc_expect.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dss_pkg.sv
hw/rtl/dss_cell.sv
hw/rtl/disk_seek_scheduler_top.sv
hw/rtl/dss_checker.sv
sim/disk_seek_scheduler_top_tb.sv
